>>> hdl/jetp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jetp_pkg
// Shared constants, types and helpers for the Julia escape-time pixel engine.
// ----------------------------------------------------------------------------
package jetp_pkg;

  localparam int unsigned MAX_ITER_DEF   = 256;
  localparam int unsigned IMG_WIDTH_DEF  = 800;
  localparam int unsigned IMG_HEIGHT_DEF = 600;

  localparam int unsigned Q_FRAC  = 28;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned SPAN_W  = 33;
  localparam int unsigned MUL_W   = 2 * SPAN_W;
  // |span * pos| stays below 2^43
  localparam int unsigned DIVD_W  = SPAN_W + POS_W;

  localparam logic [63:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MIN_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MAX_RE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MIN_IM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MAX_IM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_RE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IM   = 3'd5;

  localparam logic [31:0] RST_WIN_MIN_RE = 32'hE000_0000;
  localparam logic [31:0] RST_WIN_MAX_RE = 32'h2000_0000;
  localparam logic [31:0] RST_WIN_MIN_IM = 32'hE800_0000;
  localparam logic [31:0] RST_WIN_MAX_IM = 32'h1800_0000;
  localparam logic [31:0] RST_CONST_RE   = 32'd76504269;
  localparam logic [31:0] RST_CONST_IM   = 32'd3758096;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [31:0] sat32(input logic signed [44:0] v);
    logic [31:0] r;
    if (v > 45'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -45'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/julia_escape_time_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_pixel
// Escape-time engine: maps a pixel into the window and iterates z = z^2 + c.
// ----------------------------------------------------------------------------
//  channel  | dir | word                                   | handshake
//  s_axis   | in  | tdata: pixel_col, pixel_row            | tvalid/tready
//  m_axis   | out | tdata: iteration_count, escaped, mag   | tvalid/tready
//  cfg      | in  | index + 32-bit register value          | valid/ready
//
//  A pixel runs 1 to MAX_ITER updates of z after mapping: each axis maps
//  through a reciprocal divider taking 11-bit digits, then one shared 33x33
//  multiplier forms three products per update.
//  s_axis_tready is high only while idle; a finished word waits in the output
//  register, and the next pixel may start meanwhile.
//  Reset restores the register defaults; cfg writes are always taken.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel
  import jetp_pkg::*;
#(
  parameter int unsigned MAX_ITER   = MAX_ITER_DEF,
  parameter int unsigned IMG_WIDTH  = IMG_WIDTH_DEF,
  parameter int unsigned IMG_HEIGHT = IMG_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // pixel_col[9:0], pixel_row[19:10]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,  // iteration_count[8:0], escaped[9],
                                              // final_magnitude[41:10]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned CNT_W   = $clog2(MAX_ITER + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MMUL   = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_MDIV   = 4'd3;
  localparam logic [3:0] S_RR     = 4'd4;
  localparam logic [3:0] S_II     = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_RI     = 4'd7;
  localparam logic [3:0] S_UPD    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [31:0] win_min_re_q, win_max_re_q, win_min_im_q, win_max_im_q;
  logic [31:0] const_re_q, const_im_q;

  logic [3:0]        state_q;
  logic              axis_q;
  logic              first_q;
  logic              neg_q;
  logic              esc_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [POS_W-1:0]  col_q, row_q;
  logic [31:0]       re_q, im_q;
  logic [MUL_W-1:0]  p_q;
  logic [63:0]       rr_q, ii_q, mag_q;

  logic              m_valid_q;
  logic [8:0]        out_cnt_q;
  logic              out_esc_q;
  logic [31:0]       out_mag_q;
  logic              out_load;

  logic signed [SPAN_W-1:0] span_re, span_im, mul_a, mul_b;
  logic signed [MUL_W-1:0]  prod;
  logic signed [DIVD_W:0]   pabs_s;
  logic [DIVD_W-1:0]        div_dividend;
  logic [DIVD_W-1:0]        div_quo;
  div_status_t              div_st;
  logic                     div_start;

  logic signed [DIVD_W:0]   off;
  logic signed [44:0]       map_sum;
  logic [63:0]              mag_sum;
  logic signed [63:0]       rr_ii;
  logic signed [44:0]       nre_sum, nim_sum;
  logic [35:0]              mag_hi;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_min_re_q <= RST_WIN_MIN_RE;
      win_max_re_q <= RST_WIN_MAX_RE;
      win_min_im_q <= RST_WIN_MIN_IM;
      win_max_im_q <= RST_WIN_MAX_IM;
      const_re_q   <= RST_CONST_RE;
      const_im_q   <= RST_CONST_IM;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIN_MIN_RE: win_min_re_q <= cfg_data_i;
        REG_WIN_MAX_RE: win_max_re_q <= cfg_data_i;
        REG_WIN_MIN_IM: win_min_im_q <= cfg_data_i;
        REG_WIN_MAX_IM: win_max_im_q <= cfg_data_i;
        REG_CONST_RE:   const_re_q   <= cfg_data_i;
        REG_CONST_IM:   const_im_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier
  assign span_re = $signed({win_max_re_q[31], win_max_re_q})
                 - $signed({win_min_re_q[31], win_min_re_q});
  assign span_im = $signed({win_max_im_q[31], win_max_im_q})
                 - $signed({win_min_im_q[31], win_min_im_q});

  always_comb begin
    case (state_q)
      S_MMUL: begin
        mul_a = axis_q ? span_im : span_re;
        mul_b = $signed({{(SPAN_W-POS_W){1'b0}}, (axis_q ? row_q : col_q)});
      end
      S_RR: begin
        mul_a = $signed({re_q[31], re_q});
        mul_b = $signed({re_q[31], re_q});
      end
      S_II: begin
        mul_a = $signed({im_q[31], im_q});
        mul_b = $signed({im_q[31], im_q});
      end
      S_RI: begin
        mul_a = $signed({re_q[31], re_q});
        mul_b = $signed({im_q[31], im_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // axis mapping through the constant divider
  assign pabs_s       = p_q[DIVD_W] ? -$signed(p_q[DIVD_W:0]) : $signed(p_q[DIVD_W:0]);
  assign div_dividend = pabs_s[DIVD_W-1:0];
  assign div_start    = (state_q == S_MSTART);

  jetp_div #(
    .DD_W  (DIVD_W),
    .DIV_A (IMG_WIDTH),
    .DIV_B (IMG_HEIGHT)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .sel_i      (axis_q),
    .dividend_i (div_dividend),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  assign off     = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign map_sum = $signed({{13{(axis_q ? win_min_im_q[31] : win_min_re_q[31])}},
                            (axis_q ? win_min_im_q : win_min_re_q)})
                 + 45'(off);

  // iteration arithmetic
  assign mag_sum = rr_q + p_q[63:0];
  assign rr_ii   = $signed(rr_q) - $signed(ii_q);
  assign nre_sum = 45'($signed(rr_ii[63:Q_FRAC])) + 45'($signed(const_re_q));
  assign nim_sum = 45'($signed(p_q[63:Q_FRAC-1])) + 45'($signed(const_im_q));

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_load      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      axis_q    <= 1'b0;
      first_q   <= 1'b0;
      esc_q     <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            axis_q  <= 1'b0;
            state_q <= S_MMUL;
          end
        end
        S_MMUL:   state_q <= S_MSTART;
        S_MSTART: state_q <= S_MDIV;
        S_MDIV: begin
          if (div_st.done) begin
            if (axis_q) begin
              first_q <= 1'b1;
              esc_q   <= 1'b0;
              cnt_q   <= '0;
              state_q <= S_RR;
            end else begin
              axis_q  <= 1'b1;
              state_q <= S_MMUL;
            end
          end
        end
        S_RR: state_q <= S_II;
        S_II: state_q <= S_CHK;
        S_CHK: begin
          first_q <= 1'b0;
          if (first_q) begin
            state_q <= S_RI;
          end else if (mag_sum >= ESC_LIMIT) begin
            esc_q   <= 1'b1;
            state_q <= S_DONE;
          end else if (cnt_q == CNT_W'(MAX_ITER - 1)) begin
            cnt_q   <= CNT_W'(MAX_ITER);
            state_q <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_RI;
          end
        end
        S_RI:  state_q <= S_UPD;
        S_UPD: state_q <= S_RR;
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign mag_hi = mag_q[63:Q_FRAC];

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        col_q <= s_axis_tdata[POS_W-1:0];
        row_q <= s_axis_tdata[2*POS_W-1:POS_W];
      end
      S_MMUL: p_q <= prod;
      S_MSTART: neg_q <= p_q[DIVD_W];
      S_MDIV: begin
        if (div_st.done) begin
          if (axis_q) begin
            im_q <= sat32(map_sum);
          end else begin
            re_q <= sat32(map_sum);
          end
        end
      end
      S_RR: p_q <= prod;
      S_II: begin
        rr_q <= p_q[63:0];
        p_q  <= prod;
      end
      S_CHK: begin
        ii_q <= p_q[63:0];
        if (!first_q) begin
          mag_q <= mag_sum;
        end else begin
          mag_q <= '0;
        end
      end
      S_RI: p_q <= prod;
      S_UPD: begin
        re_q <= sat32(nre_sum);
        im_q <= sat32(nim_sum);
      end
      S_DONE: begin
        if (out_load) begin
          out_cnt_q <= 9'(cnt_q);
          out_esc_q <= esc_q;
          out_mag_q <= (|mag_hi[35:32]) ? 32'hFFFF_FFFF : mag_hi[31:0];
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, out_mag_q, out_esc_q, out_cnt_q};

endmodule

>>> hdl/jetp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jetp_div
// Unsigned divide by one of two constant divisors. The dividend is taken in
// 11-bit digits from the top; each digit is found by reciprocal multiplication
// and then the remainder by multiply-back.
// ----------------------------------------------------------------------------
module jetp_div
  import jetp_pkg::*;
#(
  parameter int unsigned DD_W  = DIVD_W,
  parameter int unsigned DIV_A = IMG_WIDTH_DEF,
  parameter int unsigned DIV_B = IMG_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              sel_i,
  input  logic [DD_W-1:0]   dividend_i,
  output logic [DD_W-1:0]   quotient_o,
  output div_status_t       status_o
);

  // divisors up to 4096: remainder fits 12 bits, trial word 23 bits
  localparam int unsigned DIG_W = 11;
  localparam int unsigned REM_W = 12;
  localparam int unsigned DVS_W = REM_W + 1;
  localparam int unsigned T_W   = DIG_W + REM_W;
  localparam int unsigned RCP_W = T_W + REM_W + 1;
  localparam int unsigned PRD_W = T_W + RCP_W;
  localparam int unsigned N_DIG = (DD_W + DIG_W - 1) / DIG_W;
  localparam int unsigned SH_W  = N_DIG * DIG_W;
  localparam int unsigned CNT_W = $clog2(N_DIG + 1);

  localparam logic [63:0]      RCP_ONE = 64'd1 << (T_W + REM_W);
  localparam logic [RCP_W-1:0] RCP_A   = RCP_W'(RCP_ONE / 64'(DIV_A) + 64'd1);
  localparam logic [RCP_W-1:0] RCP_B   = RCP_W'(RCP_ONE / 64'(DIV_B) + 64'd1);
  localparam logic [DVS_W-1:0] DVS_A   = DVS_W'(DIV_A);
  localparam logic [DVS_W-1:0] DVS_B   = DVS_W'(DIV_B);

  logic [SH_W-1:0]  sh_q, sh_d;
  logic [SH_W-1:0]  quo_q, quo_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DIG_W-1:0] dig_q, dig_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             sel_q, sel_d;
  logic             busy_q, busy_d;
  logic             phase_q, phase_d;
  logic             done_q, done_d;
  logic [T_W-1:0]   trial;
  logic [T_W-1:0]   back;
  logic [T_W-1:0]   diff;
  logic [RCP_W-1:0] rcp;
  logic [DVS_W-1:0] dvs;
  logic [PRD_W-1:0] prd;

  assign rcp   = sel_q ? RCP_B : RCP_A;
  assign dvs   = sel_q ? DVS_B : DVS_A;
  assign trial = {rem_q, sh_q[SH_W-1 -: DIG_W]};
  assign prd   = PRD_W'(trial) * PRD_W'(rcp);
  assign back  = T_W'(dig_q) * T_W'(dvs);
  assign diff  = trial - back;

  always_comb begin
    sh_d    = sh_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    if (start_i) begin
      sh_d    = SH_W'(dividend_i);
      quo_d   = '0;
      rem_d   = '0;
      cnt_d   = CNT_W'(N_DIG);
      sel_d   = sel_i;
      busy_d  = 1'b1;
      phase_d = 1'b0;
    end else if (busy_q) begin
      if (!phase_q) begin
        dig_d   = prd[T_W+REM_W +: DIG_W];
        phase_d = 1'b1;
      end else begin
        rem_d   = diff[REM_W-1:0];
        sh_d    = {sh_q[SH_W-DIG_W-1:0], {DIG_W{1'b0}}};
        quo_d   = {quo_q[SH_W-DIG_W-1:0], dig_q};
        cnt_d   = cnt_q - 1'b1;
        phase_d = 1'b0;
        if (cnt_q == CNT_W'(1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sel_q   <= 1'b0;
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dig_q <= dig_d;
  end

  assign quotient_o      = quo_q[DD_W-1:0];
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

>>> tb/tb_julia_escape_time_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_julia_escape_time_pixel
// Self-checking bench for the Julia escape-time pixel engine. A plan of pixel
// words, register writes, drains and idling changes is built up front and
// played by a clocked driver; each accepted pixel is run through a local
// escape-time calculation and the result word is checked field by field.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_pixel;
  import jetp_pkg::*;

  typedef enum logic [1:0] {
    ACT_PIXEL,
    ACT_WRITE,
    ACT_DRAIN,
    ACT_PACE
  } plan_act_e;

  typedef struct packed {
    plan_act_e             act;
    logic [CFG_IDX_W-1:0]  idx;
    logic [31:0]           data;
  } plan_step_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [8:0]  iters;
    logic        escaped;
    logic [31:0] magnitude;
  } escape_result_t;

  localparam longint Q428_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q428_MIN = -64'sh0000_0000_8000_0000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;  // pixel_col[9:0], pixel_row[19:10]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;       // iteration_count[8:0], escaped[9],
                                            // final_magnitude[41:10]
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  plan_step_t     pixel_plan[$];
  escape_result_t escape_q[$];
  logic [31:0]    shadow_reg [6];

  int unsigned idle_pct = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_done = 0;
  int unsigned mismatches = 0;
  int unsigned n_escaped = 0;
  int unsigned n_settings = 0;

  julia_escape_time_pixel DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // escape-time calculation
  // --------------------------------------------------------------------------
  function automatic longint clamp_q428(longint v);
    if (v > Q428_MAX) begin
      return Q428_MAX;
    end
    if (v < Q428_MIN) begin
      return Q428_MIN;
    end
    return v;
  endfunction

  function automatic longint axis_start(logic [31:0] lo, logic [31:0] hi,
                                        logic [9:0] pos, longint size);
    longint lo_s;
    longint span;
    lo_s = longint'($signed(lo));
    span = longint'($signed(hi)) - lo_s;
    // signed divide truncates towards zero
    return clamp_q428(lo_s + span * longint'({54'd0, pos}) / size);
  endfunction

  function automatic escape_result_t escape_time(logic [9:0] col, logic [9:0] row);
    escape_result_t r;
    longint         re;
    longint         im;
    longint         nre;
    longint         nim;
    longint         c_re;
    longint         c_im;
    logic [63:0]    mag;
    int unsigned    n;
    logic           hit;
    re   = axis_start(shadow_reg[REG_WIN_MIN_RE], shadow_reg[REG_WIN_MAX_RE], col,
                      longint'(IMG_WIDTH_DEF));
    im   = axis_start(shadow_reg[REG_WIN_MIN_IM], shadow_reg[REG_WIN_MAX_IM], row,
                      longint'(IMG_HEIGHT_DEF));
    c_re = longint'($signed(shadow_reg[REG_CONST_RE]));
    c_im = longint'($signed(shadow_reg[REG_CONST_IM]));
    mag  = '0;
    n    = 0;
    hit  = 1'b0;
    while (!hit && n < MAX_ITER_DEF) begin
      // products at Q8.56, floored back to Q.28
      nre = clamp_q428(((re * re - im * im) >>> Q_FRAC) + c_re);
      nim = clamp_q428(((re * im) >>> (Q_FRAC - 1)) + c_im);
      re  = nre;
      im  = nim;
      mag = re * re + im * im;
      if (mag >= ESC_LIMIT) begin
        hit = 1'b1;
      end else begin
        n++;
      end
    end
    r.col       = col;
    r.row       = row;
    r.iters     = n[8:0];
    r.escaped   = hit;
    r.magnitude = (mag[63:Q_FRAC+32] != '0) ? 32'hFFFF_FFFF : mag[Q_FRAC+31:Q_FRAC];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // plan building
  // --------------------------------------------------------------------------
  task automatic add_step(plan_act_e act, logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    plan_step_t s;
    s.act  = act;
    s.idx  = idx;
    s.data = data;
    pixel_plan.push_back(s);
  endtask

  task automatic add_pixel(int unsigned col, int unsigned row);
    add_step(ACT_PIXEL, '0, {12'd0, row[9:0], col[9:0]});
  endtask

  // block must be idle before any register write
  task automatic add_setting(logic [31:0] lo_re, logic [31:0] hi_re, logic [31:0] lo_im,
                             logic [31:0] hi_im, logic [31:0] c_re, logic [31:0] c_im);
    add_step(ACT_DRAIN, '0, '0);
    add_step(ACT_WRITE, REG_WIN_MIN_RE, lo_re);
    add_step(ACT_WRITE, REG_WIN_MAX_RE, hi_re);
    add_step(ACT_WRITE, REG_WIN_MIN_IM, lo_im);
    add_step(ACT_WRITE, REG_WIN_MAX_IM, hi_im);
    add_step(ACT_WRITE, REG_CONST_RE, c_re);
    add_step(ACT_WRITE, REG_CONST_IM, c_im);
    n_settings++;
  endtask

  task automatic add_random_setting();
    longint      ctr_re;
    longint      ctr_im;
    longint      half_re;
    longint      half_im;
    logic [31:0] lo_re;
    logic [31:0] hi_re;
    logic [31:0] lo_im;
    logic [31:0] hi_im;
    logic [31:0] c_re;
    logic [31:0] c_im;
    logic [31:0] tmp;
    ctr_re  = longint'($urandom_range(805306368)) - 402653184;
    ctr_im  = longint'($urandom_range(805306368)) - 402653184;
    half_re = longint'($urandom_range(536870912, 2684354));
    half_im = longint'($urandom_range(536870912, 2684354));
    lo_re   = 32'(ctr_re - half_re);
    hi_re   = 32'(ctr_re + half_re);
    lo_im   = 32'(ctr_im - half_im);
    hi_im   = 32'(ctr_im + half_im);
    if ($urandom_range(7) == 0) begin
      tmp   = lo_re;
      lo_re = hi_re;
      hi_re = tmp;
    end
    if ($urandom_range(7) == 0) begin
      tmp   = lo_im;
      lo_im = hi_im;
      hi_im = tmp;
    end
    if ($urandom_range(15) == 0) begin
      hi_im = lo_im;
    end
    case ($urandom_range(6))
      0: begin c_re = RST_CONST_RE;   c_im = RST_CONST_IM;   end
      1: begin c_re = -32'sd214748365; c_im = 32'sd41875931;  end
      2: begin c_re = -32'sd107374182; c_im = 32'sd161061274; end
      3: begin c_re = 32'sd95294587;   c_im = 32'sd95294587;  end
      4: begin c_re = -32'sd188377266; c_im = -32'sd103132902; end
      5: begin c_re = '0;              c_im = 32'sd214748365; end
      default: begin c_re = $urandom; c_im = $urandom; end
    endcase
    c_re = c_re + $urandom_range(2097152) - 32'd1048576;
    c_im = c_im + $urandom_range(2097152) - 32'd1048576;
    if ($urandom_range(9) == 0) begin
      add_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      add_setting(lo_re, hi_re, lo_im, hi_im, c_re, c_im);
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: pixel words and register writes
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic       nxt_pix_vld;
    logic       nxt_cfg_vld;
    plan_step_t step;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
      gap_left      = 0;
    end else begin
      nxt_pix_vld = s_axis_tvalid;
      nxt_cfg_vld = cfg_valid_i;
      if (s_axis_tvalid && s_axis_tready) begin
        escape_q.push_back(escape_time(s_axis_tdata[9:0], s_axis_tdata[19:10]));
        pixels_sent++;
        nxt_pix_vld = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_reg[cfg_index_i] = cfg_data_i;
        nxt_cfg_vld = 1'b0;
      end
      if (!nxt_pix_vld && !nxt_cfg_vld) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pixel_plan.size() != 0) begin
          step = pixel_plan[0];
          case (step.act)
            ACT_PIXEL: begin
              nxt_pix_vld = 1'b1;
              s_axis_tdata <= {4'd0, step.data[19:0]};
              void'(pixel_plan.pop_front());
              if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                gap_left = $urandom_range(14, 1);
              end
            end
            ACT_WRITE: begin
              nxt_cfg_vld = 1'b1;
              cfg_index_i <= step.idx;
              cfg_data_i  <= step.data;
              void'(pixel_plan.pop_front());
            end
            ACT_DRAIN: begin
              if (results_done == pixels_sent) begin
                void'(pixel_plan.pop_front());
              end
            end
            default: begin
              idle_pct <= step.data;
              void'(pixel_plan.pop_front());
            end
          endcase
        end
      end
      s_axis_tvalid <= nxt_pix_vld;
      cfg_valid_i   <= nxt_cfg_vld;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: result words
  // --------------------------------------------------------------------------
  task automatic check_field(string what, logic [31:0] want, logic [31:0] got,
                             escape_result_t item);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 50) begin
        $display("%0t: pixel (%0d,%0d) %s expected %0h got %0h", $time, item.col,
                 item.row, what, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    escape_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      results_done  <= 0;
      stall_left    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (escape_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 50) begin
            $display("%0t: result word expected none got %0h", $time, m_axis_tdata);
          end
        end else begin
          want = escape_q.pop_front();
          results_done <= results_done + 1;
          if (want.escaped) begin
            n_escaped++;
          end
          check_field("iteration_count", 32'(want.iters), 32'(m_axis_tdata[8:0]), want);
          check_field("escaped", 32'(want.escaped), 32'(m_axis_tdata[9]), want);
          check_field("final_magnitude", want.magnitude, m_axis_tdata[41:10], want);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(14, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pace;
    shadow_reg[REG_WIN_MIN_RE] = RST_WIN_MIN_RE;
    shadow_reg[REG_WIN_MAX_RE] = RST_WIN_MAX_RE;
    shadow_reg[REG_WIN_MIN_IM] = RST_WIN_MIN_IM;
    shadow_reg[REG_WIN_MAX_IM] = RST_WIN_MAX_IM;
    shadow_reg[REG_CONST_RE]   = RST_CONST_RE;
    shadow_reg[REG_CONST_IM]   = RST_CONST_IM;

    // reset window: corners, centre, past the image edge, alternating bits
    add_step(ACT_PACE, '0, 32'd25);
    add_pixel(0, 0);
    add_pixel(799, 599);
    add_pixel(0, 599);
    add_pixel(799, 0);
    add_pixel(400, 300);
    add_pixel(1023, 1023);
    add_pixel(800, 600);
    add_pixel(10'h2AA, 10'h155);
    add_pixel(10'h155, 10'h2AA);
    add_step(ACT_DRAIN, '0, '0);
    add_pixel(200, 150);

    // full-range and inverted window, extreme c: clamped components, saturation
    add_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000);
    add_pixel(0, 0);
    add_pixel(1023, 1023);
    add_pixel(400, 300);
    add_pixel(799, 599);

    // empty window at the origin, c = -2: magnitude lands exactly on four
    add_setting('0, '0, '0, '0, 32'hE000_0000, '0);
    add_step(ACT_PACE, '0, '0);
    add_pixel(0, 0);
    add_pixel(1023, 0);
    add_pixel(0, 1023);

    // empty window, c = 0: stays at zero for every iteration
    add_setting('0, '0, '0, '0, '0, '0);
    add_pixel(5, 5);
    add_pixel(799, 599);

    for (int p = 0; p < 8; p++) begin
      add_random_setting();
      pace = (p == 2 || p == 7) ? 0 : $urandom_range(50, 10);
      add_step(ACT_PACE, '0, pace);
      for (int i = 0; i < 154; i++) begin
        if ($urandom_range(63) == 0) begin
          add_step(ACT_DRAIN, '0, '0);
        end
        if ($urandom_range(7) == 0) begin
          add_pixel($urandom_range(1023), $urandom_range(1023));
        end else begin
          add_pixel($urandom_range(799), $urandom_range(599));
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_plan.size() != 0 || s_axis_tvalid || cfg_valid_i ||
           results_done != pixels_sent) begin
      @(negedge clk_i);
    end
    repeat (1500) @(posedge clk_i);

    $display("pixels checked: %0d over %0d register settings plus reset values",
             results_done, n_settings);
    $display("escaped: %0d, bounded to the iteration limit: %0d, mismatches: %0d",
             n_escaped, results_done - n_escaped, mismatches);
    if (mismatches == 0) begin
      $display("tb_julia_escape_time_pixel: done, clean");
    end else begin
      $display("tb_julia_escape_time_pixel: done, errors");
    end
    $finish;
  end

  initial begin
    #120_000_000;
    $display("timeout: %0d pixels sent, %0d results back", pixels_sent, results_done);
    $display("tb_julia_escape_time_pixel: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
hdl/jetp_pkg.sv
hdl/jetp_div.sv
hdl/julia_escape_time_pixel.sv
tb/tb_julia_escape_time_pixel.sv
